// ----- rtl/mtpi_pkg.sv -----
// Shared widths, codes and parameter defaults of the masked temporal pixel interpolator.
`default_nettype none

package mtpi_pkg;

  localparam int unsigned MAX_SAMPLES_DEF      = 4;
  localparam int unsigned WEIGHT_FRAC_BITS_DEF = 20;

  localparam int unsigned WEIGHT_W   = 24;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned WADDR_W    = 6;
  localparam int unsigned NCFG_W     = 3;
  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned S_TUSER_W  = 2;
  localparam int unsigned M_TDATA_W  = 16;

  localparam logic [NCFG_W-1:0] SAMPLES_RST = 3'd4;

  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/mtpi_weight_ram.sv -----
// Weight table memory: one write port, one read port with registered read data.
`default_nettype none

module mtpi_weight_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = mtpi_pkg::WEIGHT_W
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/masked_temporal_pixel_interpolator.sv -----
// Top level of the masked temporal pixel interpolator: sample gathering and MAC sequencer.
//
// Input beats on the s_axis channel either write one weight table entry (tuser[0] low)
// or deliver one time sample of a pixel (tuser[0] high, tuser[1] marks a missing sample).
// A weight write or a sample that does not complete a pixel leaves the sequencer idle.
// The sample that completes a pixel starts the sequencer: for each of the n samples the
// shared 24x16 multiplier steps through the weight read, multiply and accumulate states,
// then a round state rounds, saturates and loads the output register behind m_axis_tvalid;
// s_axis_tready stays low until the sequencer is idle again, also during any output wait.
// Results leave on m_axis from an output register, so gathering of the next pixel goes on
// while the receiver stalls; the sequencer only waits in its round state when the output
// register is still full.
// The cfg channel writes samples_in_use and drops any partly gathered pixel; it is ready
// only while the sequencer is idle, and a pending cfg beat holds off s_axis.
// Reset sets samples_in_use to 4, empties the output register and drops gathered samples.
// The weight table is not cleared; every entry must be written before it is used.
`default_nettype none

module masked_temporal_pixel_interpolator #(
  parameter int unsigned MAX_SAMPLES      = mtpi_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned WEIGHT_FRAC_BITS = mtpi_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // cfg data: samples_in_use [2:0]
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [mtpi_pkg::NCFG_W-1:0]      cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // weight_addr [5:0], weight_value [29:6], sample_value [45:30], zero [47:46]
  input  wire logic [mtpi_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // func [0], sample_missing [1]
  input  wire logic [mtpi_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // pixel_value [15:0]
  output logic      [mtpi_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // saturated
  output logic                                  m_axis_tuser
);

  localparam int unsigned DEPTH   = MAX_SAMPLES << MAX_SAMPLES;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned XW      = (AW > mtpi_pkg::WADDR_W) ? AW : mtpi_pkg::WADDR_W;
  localparam int unsigned NW      = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SIW     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned PW      = NW + MAX_SAMPLES;
  localparam int unsigned PROD_W  = mtpi_pkg::WEIGHT_W + mtpi_pkg::SAMPLE_W;
  localparam int unsigned ACC_W   = PROD_W + NW;
  localparam int unsigned RW      = ACC_W + 1;
  localparam int unsigned OW      = mtpi_pkg::SAMPLE_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_ACC   = 5'b01000,
    ST_ROUND = 5'b10000
  } state_e;

  state_e                         state_q, state_d;
  logic [mtpi_pkg::NCFG_W-1:0]    ncfg_q, ncfg_d;
  logic [NW-1:0]                  count_q, count_d;
  logic [MAX_SAMPLES-1:0]         code_q, code_d;
  logic [NW-1:0]                  idx_q, idx_d;
  logic [AW-1:0]                  addr_q, addr_d;
  logic                           out_valid_q, out_valid_d;
  logic [OW-1:0]                  out_pix_q;
  logic                           out_sat_q;
  logic signed [mtpi_pkg::SAMPLE_W-1:0] buf_q [MAX_SAMPLES];
  logic signed [mtpi_pkg::SAMPLE_W-1:0] smp_q;
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [ACC_W-1:0]        acc_q;

  logic                           in_beat, cfg_beat, out_beat;
  logic                           func;
  logic                           miss;
  logic [mtpi_pkg::WADDR_W-1:0]   waddr;
  logic [XW-1:0]                  waddr_x;
  logic [mtpi_pkg::WEIGHT_W-1:0]  wvalue;
  logic [mtpi_pkg::SAMPLE_W-1:0]  svalue;
  logic [NW-1:0]                  n_eff;
  logic [NW-1:0]                  count_inc;
  logic [MAX_SAMPLES-1:0]         code_new;
  logic [PW-1:0]                  base_full;
  logic                           ram_we, ram_re;
  logic [mtpi_pkg::WEIGHT_W-1:0]  ram_rdata;
  logic signed [RW-1:0]           rsum;
  logic signed [RW-1:0]           shifted;
  logic                           hi_ones, hi_zeros;
  logic                           sat;
  logic [OW-1:0]                  pix;
  logic                           load_out;

  assign func    = s_axis_tuser[0];
  assign miss    = s_axis_tuser[1];
  assign waddr   = s_axis_tdata[5:0];
  assign wvalue  = s_axis_tdata[29:6];
  assign svalue  = s_axis_tdata[45:30];
  assign waddr_x = XW'(waddr);

  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign cfg_beat      = cfg_valid_i && cfg_ready_o;
  assign out_beat      = m_axis_tvalid && m_axis_tready;

  always_comb begin
    priority if (ncfg_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(ncfg_q) > MAX_SAMPLES) begin
      n_eff = NW'(MAX_SAMPLES);
    end else begin
      n_eff = NW'(ncfg_q);
    end
  end

  assign count_inc = NW'(count_q + 1'b1);
  assign code_new  = code_q | (MAX_SAMPLES'(miss) << count_q[SIW-1:0]);
  assign base_full = PW'(n_eff * code_new);

  assign ram_we = in_beat && (func == mtpi_pkg::FUNC_WEIGHT) && (32'(waddr) < DEPTH);
  assign ram_re = (state_q == ST_READ);

  mtpi_weight_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (mtpi_pkg::WEIGHT_W)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr_x[AW-1:0]),
    .wdata_i (wvalue),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign rsum     = RW'(acc_q) + (RW'(1) << (WEIGHT_FRAC_BITS - 1));
  assign shifted  = rsum >>> WEIGHT_FRAC_BITS;
  assign hi_ones  = &shifted[RW-1:OW-1];
  assign hi_zeros = ~|shifted[RW-1:OW-1];
  assign sat      = !(hi_ones || hi_zeros);
  assign pix      = sat ? {shifted[RW-1], {(OW-1){~shifted[RW-1]}}} : shifted[OW-1:0];
  assign load_out = (state_q == ST_ROUND) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    ncfg_d      = ncfg_q;
    count_d     = count_q;
    code_d      = code_q;
    idx_d       = idx_q;
    addr_d      = addr_q;
    out_valid_d = out_valid_q;
    if (out_beat) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (cfg_beat) begin
          ncfg_d  = cfg_data_i;
          count_d = '0;
          code_d  = '0;
        end else if (in_beat && (func == mtpi_pkg::FUNC_SAMPLE)) begin
          code_d = code_new;
          if (count_inc == n_eff) begin
            count_d = '0;
            idx_d   = '0;
            addr_d  = base_full[AW-1:0];
            state_d = ST_READ;
          end else begin
            count_d = count_inc;
          end
        end
      end
      ST_READ: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        addr_d = AW'(addr_q + 1'b1);
        idx_d  = NW'(idx_q + 1'b1);
        if (NW'(idx_q + 1'b1) == n_eff) begin
          state_d = ST_ROUND;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_ROUND: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          code_d      = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ncfg_q      <= mtpi_pkg::SAMPLES_RST;
      count_q     <= '0;
      code_q      <= '0;
      idx_q       <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ncfg_q      <= ncfg_d;
      count_q     <= count_d;
      code_q      <= code_d;
      idx_q       <= idx_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat && (func == mtpi_pkg::FUNC_SAMPLE)) begin
      buf_q[count_q[SIW-1:0]] <= svalue;
    end
    if ((state_q == ST_IDLE) && (state_d == ST_READ)) begin
      acc_q <= '0;
    end else if ((state_q == ST_ACC) && !code_q[idx_q[SIW-1:0]]) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (state_q == ST_READ) begin
      smp_q <= buf_q[idx_q[SIW-1:0]];
    end
    if (state_q == ST_MUL) begin
      prod_q <= $signed(ram_rdata) * smp_q;
    end
    if (load_out) begin
      out_pix_q <= pix;
      out_sat_q <= sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tuser  = out_sat_q;

endmodule

`default_nettype wire
